@@ rtl/core/armc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armc_pkg
// Shared types and constants for the sample rate converter.
// ----------------------------------------------------------------------------
package armc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int PCM_W    = 16;
    localparam int RATE_W   = 16;
    localparam int FRAME_W  = 11;
    localparam int PHASE_W  = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd32000;
    localparam logic [RATE_W-1:0]  STEP_RESET  = 16'd31440;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 11'd533;
    localparam logic [PHASE_W-1:0] PHASE_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTPUT_RATE       = 2'd0,
        REG_SOURCE_STEP       = 2'd1,
        REG_SAMPLES_PER_FRAME = 2'd2,
        REG_MIX_ENABLE        = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [RATE_W-1:0]  output_rate;
        logic [RATE_W-1:0]  source_step;
        logic [FRAME_W-1:0] samples_per_frame;
        logic               mix_enable;
    } cfg_t;

    // classified request from the front end
    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_sample;
        logic                    frame_start;
    } cmd_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_sample;
        logic                    last_in_run;
    } res_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EMIT,
        B_ADD
    } back_state_t;

endpackage

@@ rtl/core/armc_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armc_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module armc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      wr_ptr_next;
    logic [AW:0]      rd_ptr_reg;
    logic [AW:0]      rd_ptr_next;
    logic [AW:0]      fill;
    logic             do_push;
    logic             do_pop;

    assign fill    = wr_ptr_reg - rd_ptr_reg;
    assign full    = (fill == (AW+1)'(DEPTH));
    assign empty   = (fill == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg[AW-1:0] == AW'(DEPTH - 1)) ?
                          {~wr_ptr_reg[AW], {AW{1'b0}}} : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg[AW-1:0] == AW'(DEPTH - 1)) ?
                          {~rd_ptr_reg[AW], {AW{1'b0}}} : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg[AW-1:0]] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg[AW-1:0]];

endmodule

@@ rtl/core/armc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armc_front
// Accepts source sample pairs, forms the PCM value and queues a request.
// ----------------------------------------------------------------------------
module armc_front (
    input  logic                                 push,
    output logic                                 full,
    input  logic [armc_pkg::SAMPLE_W-1:0]        first_sample,
    input  logic [armc_pkg::SAMPLE_W-1:0]        second_sample,
    input  logic                                 frame_start,
    input  logic                                 mix_enable,
    input  logic                                 cmd_full,
    output logic                                 cmd_push,
    output armc_pkg::cmd_t                       cmd
);

    import armc_pkg::*;

    logic [SAMPLE_W:0]   sum;
    logic [SAMPLE_W-1:0] level;

    // averaged or single sample, still offset by 128
    assign sum   = {1'b0, first_sample} + {1'b0, second_sample};
    assign level = mix_enable ? sum[SAMPLE_W:1] : first_sample;

    // drop the offset by flipping the top bit, then scale by 256
    assign cmd.pcm_sample  = {~level[SAMPLE_W-1], level[SAMPLE_W-2:0], 8'h00};
    assign cmd.frame_start = frame_start;

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

endmodule

@@ rtl/core/armc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armc_back
// Phase accumulator: runs the emission loop for one request at a time.
// ----------------------------------------------------------------------------
module armc_back #(
    parameter int MAX_FRAME_SAMPLES = 1024,
    parameter int MAX_EMITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  armc_pkg::cfg_t  cfg,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    input  armc_pkg::cmd_t  cmd,
    input  logic            res_full,
    output logic            res_push,
    output armc_pkg::res_t  res
);

    import armc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int NW = $clog2(MAX_EMITS + 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [PHASE_W-1:0]  phase_reg;
    logic [CW-1:0]       count_reg;
    logic [NW-1:0]       n_reg;
    logic signed [PCM_W-1:0] pcm_reg;

    logic [CW-1:0]       limit;
    logic                cond;
    logic                last;
    logic [CW:0]         count_inc;
    logic [PHASE_W:0]    step_x2;
    logic [PHASE_W:0]    phase_sum;
    logic [PHASE_W-1:0]  phase_sat;

    always_comb
    begin
        if (32'(cfg.samples_per_frame) > 32'(MAX_FRAME_SAMPLES))
        begin
            limit = CW'(MAX_FRAME_SAMPLES);
        end
        else
        begin
            limit = CW'(cfg.samples_per_frame);
        end
    end

    assign cond = (n_reg < NW'(MAX_EMITS)) && (count_reg < limit) &&
                  (phase_reg >= PHASE_W'(cfg.source_step));

    // this emission ends the run if the next test would fail
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign step_x2   = {1'b0, cfg.source_step, 1'b0};
    assign last      = (n_reg == NW'(MAX_EMITS - 1)) ||
                       (count_inc >= {1'b0, limit}) ||
                       ({1'b0, phase_reg} < step_x2);

    assign phase_sum = {1'b0, phase_reg} + (PHASE_W+1)'(cfg.output_rate);
    assign phase_sat = phase_sum[PHASE_W] ? PHASE_MAX : phase_sum[PHASE_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (!cond || (!res_full && last))
                begin
                    state_next = B_ADD;
                end
            end
            B_ADD:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        res_push = 1'b0;
        unique case (state_reg)
            B_IDLE:  cmd_pop  = !cmd_empty;
            B_EMIT:  res_push = cond && !res_full;
            B_ADD:   ;
            default: ;
        endcase
    end

    assign res.pcm_sample  = pcm_reg;
    assign res.last_in_run = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            phase_reg <= '0;
            count_reg <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_pop)
            begin
                n_reg <= '0;
                if (cmd.frame_start)
                begin
                    phase_reg <= PHASE_W'(cfg.output_rate);
                    count_reg <= '0;
                end
            end
            else if (res_push)
            begin
                phase_reg <= phase_reg - PHASE_W'(cfg.source_step);
                count_reg <= count_inc[CW-1:0];
                n_reg     <= n_reg + 1'b1;
            end
            else if (state_reg == B_ADD)
            begin
                phase_reg <= phase_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            pcm_reg <= cmd.pcm_sample;
        end
    end

    a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NW'(MAX_EMITS))
        else $error("emission count above cap");

    a_frame_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (count_reg < limit))
        else $error("emission past frame limit");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && last) |=> (state_reg == B_ADD))
        else $error("run did not end after last result");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == B_EMIT && n_reg == '0))
        else $error("request not started cleanly");

endmodule

@@ rtl/core/audio_resample_mix_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_resample_mix_converter
// Nearest-neighbor sample rate converter with optional two-source mix.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-------------
//  input    | first_sample, second_sample, frame_start     | push / full
//  result   | pcm_sample, last_in_run                      | pop / empty
//  config   | cfg_index, cfg_data                          | cfg_write
//
// The front end queues one request per accepted item at once; the back end
// takes each request in turn: it pops it, emits its results through the phase
// accumulator one per cycle while the result queue has room, then does the
// rate add. A request with no result still passes through the emission state.
// Reset clears the queues, the phase and the frame count; config registers
// return to their defaults. A full result queue stalls the back end only;
// the request queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module audio_resample_mix_converter #(
    parameter int MAX_FRAME_SAMPLES = 1024,
    parameter int MAX_EMITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [armc_pkg::SAMPLE_W-1:0]          first_sample,
    input  logic [armc_pkg::SAMPLE_W-1:0]          second_sample,
    input  logic                                   frame_start,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [armc_pkg::PCM_W-1:0]      pcm_sample,
    output logic                                   last_in_run,
    input  logic                                   cfg_write,
    input  logic [armc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [armc_pkg::RATE_W-1:0]            cfg_data
);

    import armc_pkg::*;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic cmd_full;
    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_empty;
    logic cmd_pop;
    cmd_t cmd_out;
    logic res_full;
    logic res_push;
    res_t res_in;
    res_t res_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_OUTPUT_RATE:       cfg_next.output_rate = cfg_data;
                REG_SOURCE_STEP:       cfg_next.source_step = cfg_data;
                REG_SAMPLES_PER_FRAME: cfg_next.samples_per_frame = cfg_data[FRAME_W-1:0];
                REG_MIX_ENABLE:        cfg_next.mix_enable = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_rate       <= RATE_RESET;
            cfg_reg.source_step       <= STEP_RESET;
            cfg_reg.samples_per_frame <= FRAME_RESET;
            cfg_reg.mix_enable        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    armc_front u_front (
        .push          (push),
        .full          (full),
        .first_sample  (first_sample),
        .second_sample (second_sample),
        .frame_start   (frame_start),
        .mix_enable    (cfg_reg.mix_enable),
        .cmd_full      (cmd_full),
        .cmd_push      (cmd_push),
        .cmd           (cmd_in)
    );

    armc_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    armc_back #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
        .MAX_EMITS         (MAX_EMITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd_out),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    armc_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign pcm_sample  = res_out.pcm_sample;
    assign last_in_run = res_out.last_in_run;

endmodule

@@ test/audio_resample_mix_converter_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_resample_mix_converter_chk
// Watches the request, result and register channels of the sample rate
// converter, keeps its own phase accumulator and frame count, and compares
// every popped result against the oldest predicted one.
// ----------------------------------------------------------------------------
module audio_resample_mix_converter_chk #(
    parameter int MAX_FRAME_SAMPLES = 1024,
    parameter int MAX_EMITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic                                   full,
    input  logic [armc_pkg::SAMPLE_W-1:0]          first_sample,
    input  logic [armc_pkg::SAMPLE_W-1:0]          second_sample,
    input  logic                                   frame_start,
    input  logic                                   empty,
    input  logic                                   pop,
    input  logic signed [armc_pkg::PCM_W-1:0]      pcm_sample,
    input  logic                                   last_in_run,
    input  logic                                   cfg_write,
    input  logic [armc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [armc_pkg::RATE_W-1:0]            cfg_data,
    output int                                     pending_results,
    output int                                     quiet_tail,
    output int                                     mismatches,
    output int                                     results_checked,
    output int                                     capped_requests
);
    import armc_pkg::*;

    logic [RATE_W-1:0]  rate_q;
    logic [RATE_W-1:0]  step_q;
    logic [FRAME_W-1:0] frame_len_q;
    logic               mix_q;
    logic [PHASE_W-1:0] phase_acc;
    logic [FRAME_W-1:0] frame_count;
    res_t               pcm_due[$];
    res_t               oldest;
    int                 quiet_items;

    task automatic report(input string msg);
        $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    // Work out the results one request causes and queue them.
    task automatic predict_request(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                                   input logic fs);
        int                 limit;
        int                 n;
        logic [8:0]         pair_sum;
        logic [7:0]         level;
        logic [PHASE_W:0]   next_phase;
        res_t               r;
        limit = (frame_len_q > MAX_FRAME_SAMPLES) ? MAX_FRAME_SAMPLES : int'(frame_len_q);
        if (fs)
        begin
            phase_acc = PHASE_W'(rate_q);
            frame_count = '0;
        end
        pair_sum = {1'b0, a} + {1'b0, b};
        level = mix_q ? pair_sum[8:1] : a;
        // flipping the top bit of an offset-128 byte gives its signed value
        r.pcm_sample = {level ^ 8'h80, 8'h00};
        n = 0;
        while (n < MAX_EMITS && int'(frame_count) < limit && phase_acc >= {1'b0, step_q})
        begin
            phase_acc = phase_acc - PHASE_W'(step_q);
            frame_count++;
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            r.last_in_run = (k == n - 1);
            pcm_due.push_back(r);
        end
        next_phase = {1'b0, phase_acc} + (PHASE_W+1)'(rate_q);
        phase_acc = (next_phase > PHASE_MAX) ? PHASE_MAX : next_phase[PHASE_W-1:0];
        if (n == 0)
            quiet_items++;
        else
            quiet_items = 0;
        if (n == MAX_EMITS)
            capped_requests++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rate_q = RATE_RESET;
            step_q = STEP_RESET;
            frame_len_q = FRAME_RESET;
            mix_q = 1'b0;
            phase_acc = '0;
            frame_count = '0;
            quiet_items = 0;
            pcm_due.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_OUTPUT_RATE:       rate_q = cfg_data;
                    REG_SOURCE_STEP:       step_q = cfg_data;
                    REG_SAMPLES_PER_FRAME: frame_len_q = cfg_data[FRAME_W-1:0];
                    REG_MIX_ENABLE:        mix_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (pcm_due.size() == 0)
                    report($sformatf("unexpected result: pcm_sample %0d last_in_run %0b",
                                     pcm_sample, last_in_run));
                else
                begin
                    oldest = pcm_due.pop_front();
                    if (pcm_sample !== oldest.pcm_sample)
                        report($sformatf("pcm_sample mismatch: got %0d, expected %0d",
                                         pcm_sample, oldest.pcm_sample));
                    if (last_in_run !== oldest.last_in_run)
                        report($sformatf("last_in_run mismatch: got %0b, expected %0b",
                                         last_in_run, oldest.last_in_run));
                    results_checked++;
                end
            end
            if (push && !full)
                predict_request(first_sample, second_sample, frame_start);
        end
        // publish after the edge so the stimulus side never races the update
        pending_results <= pcm_due.size();
        quiet_tail <= quiet_items;
    end

endmodule

@@ test/audio_resample_mix_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_resample_mix_converter_tb
// Drives requests and register settings into the sample rate converter with
// random gaps and result stalls; the checker beside the block predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module audio_resample_mix_converter_tb;
    import armc_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int MAX_FRAME     = 1024;
    localparam int MAX_EMITS     = 8;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 31;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [SAMPLE_W-1:0]   first_sample = '0;
    logic [SAMPLE_W-1:0]   second_sample = '0;
    logic                  frame_start = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic signed [PCM_W-1:0] pcm_sample;
    logic                  last_in_run;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_OUTPUT_RATE;
    logic [RATE_W-1:0]     cfg_data = '0;

    int pending_results;
    int quiet_tail;
    int mismatches;
    int results_checked;
    int capped_requests;

    int send_mode = 1;
    int pop_mode = 1;
    int pop_hold = 0;
    int pop_gap;
    int cycles = 0;
    int requests_sent = 0;
    int settings_used = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    audio_resample_mix_converter #(
        .MAX_FRAME_SAMPLES(MAX_FRAME),
        .MAX_EMITS(MAX_EMITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .first_sample(first_sample),
        .second_sample(second_sample),
        .frame_start(frame_start),
        .empty(empty),
        .pop(pop),
        .pcm_sample(pcm_sample),
        .last_in_run(last_in_run),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    audio_resample_mix_converter_chk #(
        .MAX_FRAME_SAMPLES(MAX_FRAME),
        .MAX_EMITS(MAX_EMITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .first_sample(first_sample),
        .second_sample(second_sample),
        .frame_start(frame_start),
        .empty(empty),
        .pop(pop),
        .pcm_sample(pcm_sample),
        .last_in_run(last_in_run),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pending_results(pending_results),
        .quiet_tail(quiet_tail),
        .mismatches(mismatches),
        .results_checked(results_checked),
        .capped_requests(capped_requests)
    );

    // 0: back to back, 1: random gaps, 2: long gaps
    function automatic int draw_gap(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 12);
            default: return $urandom_range(6, 12);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_value();
        logic [SAMPLE_W-1:0] corners[4];
        corners = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 3)];
        return SAMPLE_W'($urandom_range(0, 255));
    endfunction

    // Result side: hold pop for a drawn number of cycles after each result.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_hold <= 0;
        end
        else if (pop)
        begin
            if (!empty)
            begin
                pop_gap = draw_gap(pop_mode);
                if (pop_gap != 0)
                begin
                    pop <= 1'b0;
                    pop_hold <= pop_gap - 1;
                end
            end
        end
        else if (pop_hold != 0)
            pop_hold <= pop_hold - 1;
        else
            pop <= 1'b1;
    end

    task automatic send_request(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                                input logic fs);
        int gap;
        gap = draw_gap(send_mode);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        first_sample <= a;
        second_sample <= b;
        frame_start <= fs;
        do
            @(posedge clk);
        while (full);
        requests_sent++;
    endtask

    // Drop push, wait for every predicted result, then let quiet requests drain.
    task automatic wait_for_idle();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat ((quiet_tail + 2) * 4 + 8) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [RATE_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] step,
                                input logic [RATE_W-1:0] frame_word,
                                input logic [RATE_W-1:0] mix_word);
        write_reg(REG_OUTPUT_RATE, rate);
        write_reg(REG_SOURCE_STEP, step);
        write_reg(REG_SAMPLES_PER_FRAME, frame_word);
        write_reg(REG_MIX_ENABLE, mix_word);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles, pending_results);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [RATE_W-1:0]  rate;
        logic [RATE_W-1:0]  step;
        logic [FRAME_W-1:0] frame_len;
        logic [31:0]        noise;
        logic               fs;
        int                 n;
        int                 frame_items;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: phase starts at zero, so the first request stays quiet.
        send_request(8'h00, 8'hFF, 1'b0);
        send_request(8'hFF, 8'h00, 1'b0);
        send_request(8'h80, 8'h7F, 1'b1);
        send_request(8'h7F, 8'h80, 1'b0);
        wait_for_idle();

        // Mixing on, two results per request, frame limit clamped to the maximum.
        program_regs(16'd40000, 16'd20000, 16'hFFFF, 16'hFFFF);
        send_request(8'h00, 8'h00, 1'b1);
        send_request(8'hFF, 8'hFF, 1'b0);
        send_request(8'h00, 8'hFF, 1'b0);
        send_request(8'h80, 8'h7F, 1'b0);
        send_request(8'h01, 8'hFE, 1'b0);
        wait_for_idle();

        // Per-request cap with the phase climbing into saturation.
        program_regs(16'hFFFF, 16'h1001, 16'h0400, 16'h0000);
        send_request(8'h55, 8'hAA, 1'b1);
        send_request(8'hAA, 8'h55, 1'b0);
        send_request(8'hFF, 8'h00, 1'b0);
        send_request(8'h00, 8'hFF, 1'b0);
        send_request(8'h80, 8'h80, 1'b0);
        wait_for_idle();

        // Zero step runs into a three-sample frame; frame start reopens it.
        program_regs(16'h0001, 16'h0000, 16'hF803, 16'hFFFE);
        send_request(8'h10, 8'h20, 1'b1);
        send_request(8'h30, 8'h40, 1'b0);
        send_request(8'hC0, 8'hD0, 1'b1);
        send_request(8'hE0, 8'hF0, 1'b0);
        wait_for_idle();

        // Empty frames: nothing may come out.
        program_regs(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001);
        send_request(8'hFF, 8'hFF, 1'b1);
        send_request(8'h00, 8'h00, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_for_idle();
            case ($urandom_range(0, 5))
                0:
                begin
                    rate = RATE_W'($urandom_range(1, 65535));
                    step = RATE_W'($urandom_range(1, 65535));
                end
                1:
                begin
                    rate = 16'hFFFF;
                    step = RATE_W'($urandom_range(0, 3));
                end
                2:
                begin
                    rate = RATE_W'($urandom_range(1, 100));
                    step = RATE_W'($urandom_range(1, 100));
                end
                3:
                begin
                    rate = RATE_W'($urandom_range(8000, 65535));
                    step = RATE_W'(32'(rate) / $urandom_range(1, 7));
                end
                4:
                begin
                    rate = 16'hFFFF;
                    step = 16'hFFFF;
                end
                default:
                begin
                    rate = RATE_RESET;
                    step = STEP_RESET;
                end
            endcase
            case ($urandom_range(0, 4))
                0:       frame_len = '0;
                1:       frame_len = FRAME_W'($urandom_range(1, 8));
                2:       frame_len = FRAME_W'(MAX_FRAME);
                3:       frame_len = FRAME_W'($urandom_range(0, 2047));
                default: frame_len = FRAME_W'($urandom_range(16, 600));
            endcase
            noise = $urandom;
            program_regs(rate, step, {noise[15:11], frame_len}, {noise[30:16], noise[31]});
            send_mode = ph % 3;
            pop_mode = $urandom_range(0, 2);

            n = 0;
            while (n < PHASE_ITEMS)
            begin
                frame_items = $urandom_range(1, 20);
                for (int k = 0; k < frame_items && n < PHASE_ITEMS; k++)
                begin
                    fs = (k == 0);
                    // stray or missing frame starts now and then
                    if ($urandom_range(0, 9) == 0)
                        fs = 1'($urandom_range(0, 1));
                    send_request(sample_value(), sample_value(), fs);
                    n++;
                    if (ph == 3 && n == PHASE_ITEMS / 2)
                        wait_for_idle();
                end
            end
        end

        wait_for_idle();
        $display("covered %0d requests over %0d register settings, %0d results checked",
                 requests_sent, settings_used, results_checked);
        $display("%0d requests reached the per-request emission cap", capped_requests);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
